@@ rtl/app_pkg.sv @@
// Package for the adaptive packet pacer: widths, register map, constants and microcode.
`timescale 1ns / 1ps

package app_pkg;

   // Field and state widths
   localparam int RATE_WIDTH        = 32;
   localparam int PAUSE_WIDTH       = 54;
   localparam int WINDOW_WIDTH      = 40;
   localparam int TIME_WIDTH        = 64;
   localparam int BYTES_WIDTH       = 64;
   localparam int BATCH_BYTES_WIDTH = 24;
   localparam int COUNT_WIDTH       = 8;
   localparam int ADDR_WIDTH        = 5;
   localparam int DATA_WIDTH        = 64;
   localparam int DIV_CNT_WIDTH     = $clog2(PAUSE_WIDTH);

   // Constants
   localparam logic [PAUSE_WIDTH-1:0]  NS_PER_SEC         = PAUSE_WIDTH'(1000000000);
   localparam logic [RATE_WIDTH-1:0]   INITIAL_RATE_RESET = 32'd25000000;
   localparam logic [RATE_WIDTH-1:0]   MIN_RATE_RESET     = 32'd1000000;
   localparam logic [COUNT_WIDTH-1:0]  BATCH_LIMIT_RESET  = 8'd32;
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET       = 40'd1000000000;
   localparam logic [BYTES_WIDTH-1:0]  HALF_RATE_MAX      = 64'h0000_0000_7fff_ffff;

   // Register indexes (byte address 8*i)
   localparam logic [1:0] REG_INITIAL_RATE = 2'd0;
   localparam logic [1:0] REG_MIN_RATE     = 2'd1;
   localparam logic [1:0] REG_BATCH_LIMIT  = 2'd2;
   localparam logic [1:0] REG_WINDOW       = 2'd3;

   // Sequencer steps
   typedef logic [2:0] step_type;
   localparam step_type STEP_WAIT   = 3'd0;
   localparam step_type STEP_ACCUM  = 3'd1;
   localparam step_type STEP_WINDOW = 3'd2;
   localparam step_type STEP_BATCH  = 3'd3;
   localparam step_type STEP_DIVIDE = 3'd4;
   localparam step_type STEP_FINISH = 3'd5;

   // Jump conditions
   typedef enum logic [2:0] {
      COND_NEVER,
      COND_NO_REQ,
      COND_FAILED,
      COND_NO_PAUSE,
      COND_DIV_BUSY,
      COND_OUT_BUSY
   } cond_type;

   // One control word: jump target when cond holds, else fall through to next
   typedef struct packed {
      cond_type cond;
      step_type jump;
      step_type next;
      logic     load;
      logic     accum;
      logic     window;
      logic     batch;
      logic     finish;
   } ctl_word_type;

   // Microcode program
   function automatic ctl_word_type ucode_rom(input step_type step);
      ctl_word_type w;
      w = '{cond: COND_NEVER, jump: STEP_WAIT, next: STEP_WAIT,
            load: 1'b0, accum: 1'b0, window: 1'b0, batch: 1'b0, finish: 1'b0};
      case (step)
         STEP_WAIT: begin
            w.cond = COND_NO_REQ;   w.jump = STEP_WAIT;   w.next = STEP_ACCUM;
            w.load = 1'b1;
         end
         STEP_ACCUM: begin
            w.cond = COND_FAILED;   w.jump = STEP_FINISH; w.next = STEP_WINDOW;
            w.accum = 1'b1;
         end
         STEP_WINDOW: begin
            w.cond = COND_NEVER;    w.jump = STEP_WINDOW; w.next = STEP_BATCH;
            w.window = 1'b1;
         end
         STEP_BATCH: begin
            w.cond = COND_NO_PAUSE; w.jump = STEP_FINISH; w.next = STEP_DIVIDE;
            w.batch = 1'b1;
         end
         STEP_DIVIDE: begin
            w.cond = COND_DIV_BUSY; w.jump = STEP_DIVIDE; w.next = STEP_FINISH;
         end
         STEP_FINISH: begin
            w.cond = COND_OUT_BUSY; w.jump = STEP_FINISH; w.next = STEP_WAIT;
            w.finish = 1'b1;
         end
         default: begin
            w.cond = COND_NEVER;    w.next = STEP_WAIT;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/app_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the pause computation.
`timescale 1ns / 1ps

module app_divider
   import app_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [PAUSE_WIDTH-1:0] numerator,
   input  logic [RATE_WIDTH-1:0]  divisor,
   output logic                   busy,
   output logic [PAUSE_WIDTH-1:0] quotient
);

   logic                     busy_ff, busy_in;
   logic [DIV_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [PAUSE_WIDTH-1:0]   quo_ff, quo_in;
   logic [RATE_WIDTH-1:0]    rem_ff, rem_in;
   logic [RATE_WIDTH-1:0]    div_ff, div_in;
   logic [RATE_WIDTH:0]      rem_shift;
   logic [RATE_WIDTH:0]      rem_diff;
   logic                     fits;

   // One shift-and-subtract step; numerator bits leave quo_ff as quotient bits enter
   always_comb begin
      rem_shift = {rem_ff, quo_ff[PAUSE_WIDTH-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = (rem_shift >= {1'b0, div_ff});
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_WIDTH'(PAUSE_WIDTH - 1);
         quo_in  = numerator;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PAUSE_WIDTH-2:0], fits};
         rem_in = fits ? rem_diff[RATE_WIDTH-1:0] : rem_shift[RATE_WIDTH-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/adaptive_packet_pacer.sv @@
// Top level of the adaptive packet pacer: microcoded sequencer, datapath and CSR port.
`timescale 1ns / 1ps

// Adaptive packet pacer.
// req_ channel: one beat per sent datagram (length, send_ok, timestamp in ns).
// rsp_ channel: one beat per request with send_failed, rate_changed, the current
// pacing rate and, at the end of a batch, pause_due with the pause in ns.
// csr port (APB style, 64-bit data, registers at byte address 8*i): initial_rate,
// min_rate, batch_limit, window_length; writing initial_rate also loads the rate.
// A request is taken only while the sequencer sits in its wait step (req_stall low).
// A request runs through the wait, accumulate, window, batch and finish steps; a failed
// send jumps from accumulate to finish, and at a batch end the divide step waits on the
// bit-serial divider for batch_bytes*1e9/rate; no request is taken until finish is left.
// The response sits in an output register, so the next request is taken while
// the previous response waits; if rsp_stall still holds when the next response
// is done, the sequencer waits in its finish step and req_stall stays high.
// Synchronous reset loads the register defaults, the initial rate, closes the
// window, clears the batch counters and drops rsp_valid.

module adaptive_packet_pacer
   import app_pkg::*;
#(
   parameter int LENGTH_WIDTH = 16
)
(
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [LENGTH_WIDTH-1:0] req_datagram_length,
   input  logic                    req_send_ok,
   input  logic [TIME_WIDTH-1:0]   req_time_ns,
   // response channel
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_send_failed,
   output logic                    rsp_rate_changed,
   output logic [RATE_WIDTH-1:0]   rsp_pacing_rate,
   output logic                    rsp_pause_due,
   output logic [PAUSE_WIDTH-1:0]  rsp_pause_ns,
   // configuration port
   input  logic                    psel,
   input  logic                    penable,
   input  logic                    pwrite,
   input  logic [ADDR_WIDTH-1:0]   paddr,
   input  logic [DATA_WIDTH-1:0]   pwdata,
   output logic [DATA_WIDTH-1:0]   prdata,
   output logic                    pready
);

   // Configuration registers
   logic [RATE_WIDTH-1:0]   initial_rate_ff, initial_rate_in;
   logic [RATE_WIDTH-1:0]   min_rate_ff, min_rate_in;
   logic [COUNT_WIDTH-1:0]  batch_limit_ff, batch_limit_in;
   logic [WINDOW_WIDTH-1:0] window_length_ff, window_length_in;

   // Pacer state
   logic                         window_open_ff, window_open_in;
   logic [TIME_WIDTH-1:0]        window_start_ff, window_start_in;
   logic [BYTES_WIDTH-1:0]       window_bytes_ff, window_bytes_in;
   logic [RATE_WIDTH-1:0]        current_rate_ff, current_rate_in;
   logic [BATCH_BYTES_WIDTH-1:0] batch_bytes_ff, batch_bytes_in;
   logic [COUNT_WIDTH-1:0]       batch_count_ff, batch_count_in;

   // Latched request and per-item flags
   logic [LENGTH_WIDTH-1:0] len_ff, len_in;
   logic                    ok_ff, ok_in;
   logic [TIME_WIDTH-1:0]   now_ff, now_in;
   logic                    changed_ff, changed_in;
   logic                    pause_ff, pause_in;

   // Sequencer and response registers
   step_type               step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_failed_ff, rsp_failed_in;
   logic                   rsp_changed_ff, rsp_changed_in;
   logic [RATE_WIDTH-1:0]  rsp_rate_ff, rsp_rate_in;
   logic                   rsp_pause_ff, rsp_pause_in;
   logic [PAUSE_WIDTH-1:0] rsp_pause_ns_ff, rsp_pause_ns_in;

   ctl_word_type           ctl;
   logic                   cond_hit;
   logic                   csr_write;
   logic                   out_busy;
   logic                   window_hit;
   logic                   pause_hit;
   logic                   div_start;
   logic                   div_busy;
   logic [PAUSE_WIDTH-1:0] div_quotient;
   logic [PAUSE_WIDTH-1:0] pause_product;
   logic [BYTES_WIDTH:0]   window_sum;
   logic [BATCH_BYTES_WIDTH:0] batch_sum;
   logic [TIME_WIDTH-1:0]  elapsed;

   // Doubled window bytes, saturated to 32 bits and floored at min_rate
   function automatic logic [RATE_WIDTH-1:0] retarget(input logic [BYTES_WIDTH-1:0] bytes,
                                                       input logic [RATE_WIDTH-1:0] floor_rate);
      logic [RATE_WIDTH-1:0] doubled;
      if (bytes > HALF_RATE_MAX) begin
         doubled = '1;
      end else begin
         doubled = {bytes[RATE_WIDTH-2:0], 1'b0};
      end
      if (doubled < floor_rate) begin
         doubled = floor_rate;
      end
      return doubled;
   endfunction

   // Control word fetch and jump condition
   assign ctl      = ucode_rom(step_ff);
   assign out_busy = rsp_valid_ff && rsp_stall;

   always_comb begin
      case (ctl.cond)
         COND_NEVER:    cond_hit = 1'b0;
         COND_NO_REQ:   cond_hit = !req_valid;
         COND_FAILED:   cond_hit = !ok_ff;
         COND_NO_PAUSE: cond_hit = !pause_hit;
         COND_DIV_BUSY: cond_hit = div_busy;
         COND_OUT_BUSY: cond_hit = out_busy;
         default:       cond_hit = 1'b0;
      endcase
      step_in = cond_hit ? ctl.jump : ctl.next;
   end

   // Datapath terms
   assign csr_write     = psel && penable && pwrite;
   assign window_sum    = {1'b0, window_bytes_ff} + (BYTES_WIDTH + 1)'(len_ff);
   assign batch_sum     = {1'b0, batch_bytes_ff} + (BATCH_BYTES_WIDTH + 1)'(len_ff);
   assign elapsed       = now_ff - window_start_ff;
   assign window_hit    = (elapsed >= TIME_WIDTH'(window_length_ff));
   assign pause_hit     = (batch_count_ff >= batch_limit_ff) && (current_rate_ff != '0);
   assign div_start     = ctl.batch && pause_hit;
   assign pause_product = PAUSE_WIDTH'(batch_bytes_ff) * NS_PER_SEC;

   // Next-state logic driven by the control word
   always_comb begin
      initial_rate_in  = initial_rate_ff;
      min_rate_in      = min_rate_ff;
      batch_limit_in   = batch_limit_ff;
      window_length_in = window_length_ff;
      window_open_in   = window_open_ff;
      window_start_in  = window_start_ff;
      window_bytes_in  = window_bytes_ff;
      current_rate_in  = current_rate_ff;
      batch_bytes_in   = batch_bytes_ff;
      batch_count_in   = batch_count_ff;
      len_in           = len_ff;
      ok_in            = ok_ff;
      now_in           = now_ff;
      changed_in       = changed_ff;
      pause_in         = pause_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_failed_in    = rsp_failed_ff;
      rsp_changed_in   = rsp_changed_ff;
      rsp_rate_in      = rsp_rate_ff;
      rsp_pause_in     = rsp_pause_ff;
      rsp_pause_ns_in  = rsp_pause_ns_ff;

      // register writes; the user must make them only while idle, the block does not enforce it
      if (csr_write) begin
         case (paddr[4:3])
            REG_INITIAL_RATE: begin
               initial_rate_in = pwdata[RATE_WIDTH-1:0];
               current_rate_in = pwdata[RATE_WIDTH-1:0];
            end
            REG_MIN_RATE:    min_rate_in      = pwdata[RATE_WIDTH-1:0];
            REG_BATCH_LIMIT: batch_limit_in   = pwdata[COUNT_WIDTH-1:0];
            REG_WINDOW:      window_length_in = pwdata[WINDOW_WIDTH-1:0];
            default:         min_rate_in      = min_rate_ff;
         endcase
      end

      // capture the request beat
      if (ctl.load && req_valid) begin
         len_in     = req_datagram_length;
         ok_in      = req_send_ok;
         now_in     = req_time_ns;
         changed_in = 1'b0;
         pause_in   = 1'b0;
      end

      // open window, saturating byte and datagram counts
      if (ctl.accum && ok_ff) begin
         if (!window_open_ff) begin
            window_open_in  = 1'b1;
            window_start_in = now_ff;
         end
         window_bytes_in = window_sum[BYTES_WIDTH] ? '1 : window_sum[BYTES_WIDTH-1:0];
         batch_bytes_in  = batch_sum[BATCH_BYTES_WIDTH] ? '1
                                                        : batch_sum[BATCH_BYTES_WIDTH-1:0];
         if (batch_count_ff != '1) begin
            batch_count_in = batch_count_ff + 1'b1;
         end
      end

      // window close and rate retarget
      if (ctl.window && window_hit) begin
         current_rate_in = retarget(window_bytes_ff, min_rate_ff);
         window_bytes_in = '0;
         window_start_in = now_ff;
         changed_in      = 1'b1;
      end

      // batch end: product goes to the divider, batch clears
      if (div_start) begin
         pause_in       = 1'b1;
         batch_bytes_in = '0;
         batch_count_in = '0;
      end

      // response register
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (ctl.finish && !out_busy) begin
         rsp_valid_in    = 1'b1;
         rsp_failed_in   = !ok_ff;
         rsp_changed_in  = changed_ff;
         rsp_rate_in     = current_rate_ff;
         rsp_pause_in    = pause_ff;
         rsp_pause_ns_in = pause_ff ? div_quotient : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= STEP_WAIT;
         rsp_valid_ff     <= 1'b0;
         initial_rate_ff  <= INITIAL_RATE_RESET;
         min_rate_ff      <= MIN_RATE_RESET;
         batch_limit_ff   <= BATCH_LIMIT_RESET;
         window_length_ff <= WINDOW_RESET;
         window_open_ff   <= 1'b0;
         window_start_ff  <= '0;
         window_bytes_ff  <= '0;
         current_rate_ff  <= INITIAL_RATE_RESET;
         batch_bytes_ff   <= '0;
         batch_count_ff   <= '0;
      end else begin
         step_ff          <= step_in;
         rsp_valid_ff     <= rsp_valid_in;
         initial_rate_ff  <= initial_rate_in;
         min_rate_ff      <= min_rate_in;
         batch_limit_ff   <= batch_limit_in;
         window_length_ff <= window_length_in;
         window_open_ff   <= window_open_in;
         window_start_ff  <= window_start_in;
         window_bytes_ff  <= window_bytes_in;
         current_rate_ff  <= current_rate_in;
         batch_bytes_ff   <= batch_bytes_in;
         batch_count_ff   <= batch_count_in;
      end
      len_ff          <= len_in;
      ok_ff           <= ok_in;
      now_ff          <= now_in;
      changed_ff      <= changed_in;
      pause_ff        <= pause_in;
      rsp_failed_ff   <= rsp_failed_in;
      rsp_changed_ff  <= rsp_changed_in;
      rsp_rate_ff     <= rsp_rate_in;
      rsp_pause_ff    <= rsp_pause_in;
      rsp_pause_ns_ff <= rsp_pause_ns_in;
   end

   // Pause divider
   app_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (pause_product),
      .divisor   (current_rate_ff),
      .busy      (div_busy),
      .quotient  (div_quotient)
   );

   // CSR readback
   always_comb begin
      case (paddr[4:3])
         REG_INITIAL_RATE: prdata = DATA_WIDTH'(initial_rate_ff);
         REG_MIN_RATE:     prdata = DATA_WIDTH'(min_rate_ff);
         REG_BATCH_LIMIT:  prdata = DATA_WIDTH'(batch_limit_ff);
         REG_WINDOW:       prdata = DATA_WIDTH'(window_length_ff);
         default:          prdata = '0;
      endcase
   end

   // Ports
   assign pready           = 1'b1;
   assign req_stall        = (step_ff != STEP_WAIT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_send_failed  = rsp_failed_ff;
   assign rsp_rate_changed = rsp_changed_ff;
   assign rsp_pacing_rate  = rsp_rate_ff;
   assign rsp_pause_due    = rsp_pause_ff;
   assign rsp_pause_ns     = rsp_pause_ns_ff;

`ifndef SYNTHESIS
   // an accepted beat moves the sequencer straight to accumulation
   a_accept_step: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (step_ff == STEP_ACCUM))
      else $error("accepted request did not enter accumulation");

   // the divider only runs while the sequencer waits on it
   a_div_step: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (step_ff == STEP_DIVIDE))
      else $error("divider busy outside divide step");

   // a failed send reports neither a rate change nor a pause
   a_failed_quiet: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_failed) |-> (!rsp_rate_changed && !rsp_pause_due))
      else $error("failed send reported a rate change or pause");

   // pause length is zero unless a pause is due
   a_pause_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_pause_due) |-> (rsp_pause_ns == '0))
      else $error("pause length without pause_due");

   // a closed window restarts with no bytes
   a_window_clear: assert property (@(posedge clock) disable iff (reset)
      (ctl.window && window_hit) |=> (window_bytes_ff == '0))
      else $error("window bytes not cleared on retarget");
`endif

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for the adaptive packet pacer: rate, window and pause prediction.
`timescale 1ns / 1ps

module tb_top
   import app_pkg::*;
();

   localparam int LEN_W       = 16;
   localparam int CYCLE_LIMIT = 2000000;

   // One response beat as the block reports it
   typedef struct packed {
      logic                   send_failed;
      logic                   rate_changed;
      logic [RATE_WIDTH-1:0]  pacing_rate;
      logic                   pause_due;
      logic [PAUSE_WIDTH-1:0] pause_ns;
   } pacer_beat_type;

   // Pacer state tracker: predicts each response beat and checks it in order
   class pacer_scoreboard;
      logic [RATE_WIDTH-1:0]        min_rate;
      logic [COUNT_WIDTH-1:0]       batch_limit;
      logic [WINDOW_WIDTH-1:0]      window_length;
      bit                           window_open;
      logic [TIME_WIDTH-1:0]        window_start;
      logic [BYTES_WIDTH-1:0]       window_bytes;
      logic [RATE_WIDTH-1:0]        current_rate;
      logic [BATCH_BYTES_WIDTH-1:0] batch_bytes;
      logic [COUNT_WIDTH-1:0]       batch_count;
      pacer_beat_type               expected_beats[$];
      int errors, checked, pauses, retargets, failures;

      function new();
         errors = 0; checked = 0; pauses = 0; retargets = 0; failures = 0;
         clear();
      endfunction

      // state after reset
      function void clear();
         min_rate      = MIN_RATE_RESET;
         batch_limit   = BATCH_LIMIT_RESET;
         window_length = WINDOW_RESET;
         window_open   = 1'b0;
         window_start  = '0;
         window_bytes  = '0;
         current_rate  = INITIAL_RATE_RESET;
         batch_bytes   = '0;
         batch_count   = '0;
         expected_beats.delete();
      endfunction

      function void write_register(logic [1:0] idx, logic [DATA_WIDTH-1:0] value);
         case (idx)
            REG_INITIAL_RATE: current_rate  = value[RATE_WIDTH-1:0];
            REG_MIN_RATE:     min_rate      = value[RATE_WIDTH-1:0];
            REG_BATCH_LIMIT:  batch_limit   = value[COUNT_WIDTH-1:0];
            REG_WINDOW:       window_length = value[WINDOW_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      // doubled window bytes, saturated, then clamped from below
      function logic [RATE_WIDTH-1:0] retarget(logic [BYTES_WIDTH-1:0] bytes);
         logic [BYTES_WIDTH-1:0] doubled;
         if (bytes > HALF_RATE_MAX) doubled = 64'hffff_ffff;
         else doubled = bytes << 1;
         if (doubled < 64'(min_rate)) doubled = 64'(min_rate);
         return doubled[RATE_WIDTH-1:0];
      endfunction

      function void note_datagram(logic [LEN_W-1:0] len, logic ok, logic [TIME_WIDTH-1:0] stamp);
         pacer_beat_type beat;
         beat = '0;
         // failed send: report only, state untouched
         if (!ok) begin
            beat.send_failed = 1'b1;
            beat.pacing_rate = current_rate;
            failures++;
            expected_beats.push_back(beat);
            return;
         end
         if (!window_open) begin
            window_open  = 1'b1;
            window_start = stamp;
         end
         if (window_bytes > ~64'd0 - 64'(len)) window_bytes = ~64'd0;
         else window_bytes = window_bytes + 64'(len);
         // window closed: retarget and restart at this timestamp
         if (stamp - window_start >= 64'(window_length)) begin
            current_rate      = retarget(window_bytes);
            window_bytes      = '0;
            window_start      = stamp;
            beat.rate_changed = 1'b1;
            retargets++;
         end
         if (25'(batch_bytes) + 25'(len) > 25'h0ff_ffff) batch_bytes = '1;
         else batch_bytes = batch_bytes + 24'(len);
         if (batch_count != 8'hff) batch_count++;
         // batch end: pause = bytes * 1e9 / rate
         if (batch_count >= batch_limit && current_rate != 0) begin
            beat.pause_ns  = PAUSE_WIDTH'((64'(batch_bytes) * 64'(NS_PER_SEC))
                                          / 64'(current_rate));
            beat.pause_due = 1'b1;
            batch_bytes    = '0;
            batch_count    = '0;
            pauses++;
         end
         beat.pacing_rate = current_rate;
         expected_beats.push_back(beat);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 50) $display("MISMATCH beat %0d: %s", checked, msg);
      endtask

      task check_pacing(pacer_beat_type got);
         pacer_beat_type want;
         if (expected_beats.size() == 0) begin
            report("response beat with no datagram outstanding");
            return;
         end
         want = expected_beats.pop_front();
         checked++;
         if (got.send_failed !== want.send_failed)
            report($sformatf("send_failed got %0b want %0b", got.send_failed, want.send_failed));
         if (got.rate_changed !== want.rate_changed)
            report($sformatf("rate_changed got %0b want %0b",
                             got.rate_changed, want.rate_changed));
         if (got.pacing_rate !== want.pacing_rate)
            report($sformatf("pacing_rate got %0d want %0d", got.pacing_rate, want.pacing_rate));
         if (got.pause_due !== want.pause_due)
            report($sformatf("pause_due got %0b want %0b", got.pause_due, want.pause_due));
         if (got.pause_ns !== want.pause_ns)
            report($sformatf("pause_ns got %0d want %0d", got.pause_ns, want.pause_ns));
      endtask

      function int pending();
         return expected_beats.size();
      endfunction
   endclass

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic [LEN_W-1:0]        req_datagram_length = '0;
   logic                    req_send_ok = 1'b0;
   logic [TIME_WIDTH-1:0]   req_time_ns = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic                    rsp_send_failed;
   logic                    rsp_rate_changed;
   logic [RATE_WIDTH-1:0]   rsp_pacing_rate;
   logic                    rsp_pause_due;
   logic [PAUSE_WIDTH-1:0]  rsp_pause_ns;
   logic                    psel = 1'b0;
   logic                    penable = 1'b0;
   logic                    pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0]   paddr = '0;
   logic [DATA_WIDTH-1:0]   pwdata = '0;
   logic [DATA_WIDTH-1:0]   prdata;
   logic                    pready;

   pacer_scoreboard sb;
   pacer_beat_type  observed_beat;
   logic [TIME_WIDTH-1:0] stamp_ns = '0;
   int sender_idle_pct   = 20;
   int receiver_idle_pct = 63;
   int hold_cycles       = 0;
   int cycle_count       = 0;
   int datagrams_sent    = 0;

   always #5 clock = ~clock;

   adaptive_packet_pacer #(.LENGTH_WIDTH(LEN_W)) dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_datagram_length (req_datagram_length),
      .req_send_ok         (req_send_ok),
      .req_time_ns         (req_time_ns),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_failed     (rsp_send_failed),
      .rsp_rate_changed    (rsp_rate_changed),
      .rsp_pacing_rate     (rsp_pacing_rate),
      .rsp_pause_due       (rsp_pause_due),
      .rsp_pause_ns        (rsp_pause_ns),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata),
      .pready              (pready)
   );

   // Response side: check accepted beats, then pick next cycle's stall
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         observed_beat = '{rsp_send_failed, rsp_rate_changed, rsp_pacing_rate,
                           rsp_pause_due, rsp_pause_ns};
         sb.check_pacing(observed_beat);
      end
      if (hold_cycles > 0) begin
         hold_cycles = hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
      end
   end

   // Watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // APB write: setup cycle, then access cycle
   task automatic csr_write(input logic [1:0] idx, input logic [DATA_WIDTH-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      psel    <= 1'b0;
      penable <= 1'b0;
      sb.write_register(idx, value);
   endtask

   // Offer one datagram beat, with random idle cycles ahead of it
   task automatic send_datagram(input logic [LEN_W-1:0] len, input logic ok,
                                input logic [TIME_WIDTH-1:0] stamp);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_datagram_length <= len;
      req_send_ok         <= ok;
      req_time_ns         <= stamp;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_datagram(len, ok, stamp);
      datagrams_sent++;
   endtask

   // Stop offering and let every outstanding response come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic random_datagram();
      logic [LEN_W-1:0] len;
      logic             ok;
      int               pick;
      pick = $urandom_range(99);
      if (pick < 5) stamp_ns = {$urandom, $urandom};
      else if (pick < 8) stamp_ns = stamp_ns - 64'($urandom_range(1, 100000));
      else stamp_ns = stamp_ns + 64'($urandom_range(0, 4000));
      pick = $urandom_range(99);
      if (pick < 70) len = 16'($urandom);
      else if (pick < 85) len = 16'($urandom_range(0, 1500));
      else if (pick < 92) len = '0;
      else len = '1;
      ok = ($urandom_range(99) < 85);
      send_datagram(len, ok, stamp_ns);
   endtask

   // New random register settings, written only once the block is idle
   task automatic shuffle_config();
      int pick;
      wait_drained();
      if ($urandom_range(1)) begin
         pick = $urandom_range(9);
         csr_write(REG_INITIAL_RATE, (pick == 0) ? 64'd1 : (pick == 1) ? 64'hffff_ffff :
                   64'($urandom_range(100000, 100000000)));
      end
      if ($urandom_range(1)) begin
         pick = $urandom_range(19);
         csr_write(REG_MIN_RATE, (pick == 0) ? 64'd0 : (pick == 1) ? 64'hffff_ffff :
                   64'($urandom_range(1000, 10000000)));
      end
      if ($urandom_range(1)) begin
         pick = $urandom_range(9);
         csr_write(REG_BATCH_LIMIT, (pick == 0) ? 64'd1 : (pick == 1) ? 64'd255 :
                   64'($urandom_range(1, 40)));
      end
      if ($urandom_range(1)) begin
         pick = $urandom_range(9);
         csr_write(REG_WINDOW, (pick == 0) ? 64'd1 : (pick == 1) ? 64'hff_ffff_ffff :
                   64'($urandom_range(100, 20000)));
      end
   endtask

   task automatic random_phase(input int count, input int send_pct, input int recv_pct,
                               input int hold_at, input int drain_at);
      sender_idle_pct   = send_pct;
      receiver_idle_pct = recv_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) shuffle_config();
         if (i == hold_at) hold_cycles = 400;
         if (i == drain_at) wait_drained();
         random_datagram();
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: small windows and batches so every path shows up early
      csr_write(REG_INITIAL_RATE, 64'd1000000);
      csr_write(REG_MIN_RATE, 64'd1000);
      csr_write(REG_BATCH_LIMIT, 64'd2);
      csr_write(REG_WINDOW, 64'd1000);
      send_datagram(16'hffff, 1'b0, 64'd0);                  // failure before any window
      send_datagram(16'h0000, 1'b1, 64'd0);                  // window opens at time zero
      send_datagram(16'hffff, 1'b1, 64'd500);                // batch end
      send_datagram(16'd100, 1'b1, 64'd1000);                // window closes exactly
      send_datagram(16'h5555, 1'b1, 64'haaaa_aaaa_aaaa_aaaa);
      send_datagram(16'haaaa, 1'b1, 64'h5555_5555_5555_5555); // time goes back
      send_datagram(16'hffff, 1'b0, 64'hffff_ffff_ffff_ffff);
      send_datagram(16'hffff, 1'b1, 64'hffff_ffff_ffff_ffff);
      send_datagram(16'd1, 1'b1, 64'd0);                     // wraps past the top
      wait_drained();
      csr_write(REG_BATCH_LIMIT, 64'd1);
      csr_write(REG_WINDOW, 64'd1);
      csr_write(REG_INITIAL_RATE, 64'd1);
      send_datagram(16'h0000, 1'b1, 64'd10);
      send_datagram(16'h0000, 1'b1, 64'd11);                 // zero-length pause
      send_datagram(16'hffff, 1'b1, 64'd12);
      wait_drained();
      csr_write(REG_BATCH_LIMIT, 64'd255);
      csr_write(REG_WINDOW, 64'hff_ffff_ffff);
      csr_write(REG_MIN_RATE, 64'hffff_ffff);
      for (int i = 0; i < 5; i++) send_datagram(16'd1000, 1'b1, 64'(20 + i));
      wait_drained();
      csr_write(REG_BATCH_LIMIT, 64'd3);                     // limit now below the count
      send_datagram(16'd1000, 1'b1, 64'd30);
      send_datagram(16'd0, 1'b0, 64'd31);
      stamp_ns = 64'd40;

      // zero rate: empty windows retarget to zero, then batch counters saturate
      wait_drained();
      csr_write(REG_MIN_RATE, 64'd0);
      csr_write(REG_WINDOW, 64'd1);
      csr_write(REG_BATCH_LIMIT, 64'd255);
      repeat (3) begin
         stamp_ns = stamp_ns + 1;
         send_datagram(16'h0000, 1'b1, stamp_ns);
      end
      wait_drained();
      csr_write(REG_WINDOW, 64'hff_ffff_ffff);
      repeat (260) begin
         stamp_ns = stamp_ns + 1;
         send_datagram(16'hffff, 1'b1, stamp_ns);
      end
      wait_drained();
      csr_write(REG_INITIAL_RATE, 64'hffff_ffff);
      stamp_ns = stamp_ns + 1;
      send_datagram(16'hffff, 1'b1, stamp_ns);

      // random traffic under three idle mixes
      random_phase(90, 20, 63, 50, -1);
      random_phase(90, 63, 20, -1, 60);
      random_phase(60, 0, 0, -1, -1);

      // widest window: closes exactly at its full length
      wait_drained();
      csr_write(REG_WINDOW, 64'hff_ffff_ffff);
      csr_write(REG_MIN_RATE, 64'd1000);
      csr_write(REG_BATCH_LIMIT, 64'd255);
      repeat (4) begin
         stamp_ns = stamp_ns + 1;
         send_datagram(16'hffff, 1'b1, stamp_ns);
      end
      stamp_ns = sb.window_start + 64'hff_ffff_ffff;
      send_datagram(16'hffff, 1'b1, stamp_ns);

      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.pending() != 0) sb.report("expected beats left over at end of run");
      $display("Run: %0d datagrams, %0d responses, %0d pauses, %0d retargets, %0d failures",
               datagrams_sent, sb.checked, sb.pauses, sb.retargets, sb.failures);
      $display("Phases: directed edges, zero-rate saturation, three idle mixes, widest window.");
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ adaptive_packet_pacer.f @@
rtl/app_pkg.sv
rtl/app_divider.sv
rtl/adaptive_packet_pacer.sv
verif/tb_top.sv
